// File: rtl/integer_to_ascii_formatter_assert.svh
// Assertion macros used by the checker file of the formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IFMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle check that stays active while reset is asserted.
`define IFMT_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ifmt_pkg.sv
`default_nettype none
package ifmt_pkg;

    localparam int IFMT_FIFO_DEPTH = 4;
    localparam int HEX_DIGITS      = 16;
    localparam int CNT_W           = 31;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Command codes carried in the input word's user field.
    localparam logic [2:0] CMD_SDEC = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_HEXL = 3'd2;
    localparam logic [2:0] CMD_HEXU = 3'd3;
    localparam logic [2:0] CMD_PTR  = 3'd4;
    localparam logic [2:0] CMD_CLR  = 3'd5;

    // Reciprocal of ten, scaled by 2^35, exact for any 32-bit dividend.
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_MINUS,
        PRE_0X,
        PRE_NIL
    } t_pre;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        clr;
        logic        hex;
        logic        upper;
        logic        digits;
        t_pre        pre;
        logic [63:0] val;
    } t_job;

    function automatic logic [2:0] prefix_len(input t_pre pre);
        logic [2:0] len;
        case (pre)
            PRE_MINUS: len = 3'd1;
            PRE_0X:    len = 3'd2;
            PRE_NIL:   len = 3'd5;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] prefix_char(input t_pre pre, input logic [2:0] idx);
        logic [7:0] ch;
        ch = "-";
        case (pre)
            PRE_0X:  ch = (idx == 3'd0) ? "0" : "x";
            PRE_NIL: begin
                case (idx)
                    3'd0:    ch = "(";
                    3'd1:    ch = "n";
                    3'd2:    ch = "i";
                    3'd3:    ch = "l";
                    default: ch = ")";
                endcase
            end
            default: ch = "-";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = 8'h30 + {4'd0, d};
        end else if (upper) begin
            ch = 8'h37 + {4'd0, d};
        end else begin
            ch = 8'h57 + {4'd0, d};
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ifmt_front.sv
`default_nettype none
module ifmt_front
    import ifmt_pkg::*;
(
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [63:0] i_value,
    input  wire logic        i_room,
    output logic             o_ready,
    output logic             o_push,
    output t_job             o_job
);

    logic [31:0] low;
    logic        keep;

    assign low     = i_value[31:0];
    assign o_ready = i_room;

    always_comb begin
        keep          = 1'b1;
        o_job.clr     = 1'b0;
        o_job.hex     = 1'b0;
        o_job.upper   = 1'b0;
        o_job.digits  = 1'b1;
        o_job.pre     = PRE_NONE;
        o_job.val     = {32'd0, low};
        case (i_cmd)
            CMD_SDEC: begin
                // Negative values print a minus and the magnitude.
                if (low[31]) begin
                    o_job.pre = PRE_MINUS;
                    o_job.val = {32'd0, 32'd0 - low};
                end
            end
            CMD_UDEC: begin
                o_job.pre = PRE_NONE;
            end
            CMD_HEXL: begin
                o_job.hex = 1'b1;
            end
            CMD_HEXU: begin
                o_job.hex   = 1'b1;
                o_job.upper = 1'b1;
            end
            CMD_PTR: begin
                o_job.hex = 1'b1;
                o_job.val = i_value;
                if (i_value == 64'd0) begin
                    o_job.pre    = PRE_NIL;
                    o_job.digits = 1'b0;
                end else begin
                    o_job.pre = PRE_0X;
                end
            end
            CMD_CLR: begin
                o_job.clr = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Unused command codes are taken from the bus and dropped here.
    assign o_push = i_valid && i_room && keep;

endmodule
`default_nettype wire

// File: rtl/ifmt_fifo.sv
`default_nettype none
module ifmt_fifo
    import ifmt_pkg::*;
#(
    parameter int DEPTH = IFMT_FIFO_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_room,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    t_job          r_head;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_room   = (r_cnt != FULL_CNT);
    assign o_valid  = (r_cnt != '0);
    assign o_job    = r_head;
    assign do_push  = i_push && o_room;
    assign do_pop   = i_pop && o_valid;
    assign n_rd_ptr = do_pop ? ((r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1) : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        // The head word is prefetched into a register from the next read slot; a word written into that slot
        // in the same cycle is passed straight through.
        if (do_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_job;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            r_rd_ptr <= n_rd_ptr;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/ifmt_back.sv
`default_nettype none
module ifmt_back
    import ifmt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    input  t_job                   i_job,
    output logic                   o_job_pop,
    input  wire logic              i_m_ready,
    output logic                   o_m_valid,
    output logic [7:0]             o_m_char,
    output logic                   o_m_last,
    output logic [CNT_W-1:0]       o_m_count
);

    t_state           r_state;
    t_state           n_state;
    logic [63:0]      r_val;
    logic             r_hex;
    logic             r_upper;
    t_pre             r_pre;
    logic [2:0]       r_pre_left;
    logic [4:0]       r_nd;
    logic [3:0]       r_dig [HEX_DIGITS];
    logic [CNT_W-1:0] r_count;
    logic             r_m_valid;
    logic [7:0]       r_m_char;
    logic             r_m_last;
    logic [CNT_W-1:0] r_m_count;

    logic [63:0]      prod;
    logic [28:0]      quot;
    logic [32:0]      quot10;
    logic [31:0]      rem_full;
    logic [3:0]       conv_digit;
    logic [63:0]      conv_next;
    logic [2:0]       pre_idx;
    logic             emit;
    logic             emit_last;
    logic [7:0]       emit_char;
    logic [CNT_W-1:0] n_count;

    // Decimal digit: divide by ten through the scaled reciprocal.
    assign prod       = r_val[31:0] * RECIP10;
    assign quot       = prod[63:35];
    assign quot10     = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign rem_full   = r_val[31:0] - quot10[31:0];
    assign conv_digit = r_hex ? r_val[3:0] : rem_full[3:0];
    assign conv_next  = r_hex ? {4'd0, r_val[63:4]} : {35'd0, quot};

    assign pre_idx = prefix_len(r_pre) - r_pre_left;
    assign n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid && !i_job.clr) begin
                    n_state = i_job.digits ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV: begin
                if (conv_next == 64'd0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == ST_IDLE);
        emit      = (r_state == ST_EMIT) && (!r_m_valid || i_m_ready);
        if (r_pre_left != 3'd0) begin
            emit_char = prefix_char(r_pre, pre_idx);
            emit_last = (r_pre_left == 3'd1) && (r_nd == 5'd0);
        end else begin
            emit_char = digit_char(r_dig[0], r_upper);
            emit_last = (r_nd == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_IDLE) && i_job_valid && i_job.clr) begin
                r_count <= '0;
            end else if (emit) begin
                r_count <= n_count;
            end
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_job_valid) begin
            r_val      <= i_job.val;
            r_hex      <= i_job.hex;
            r_upper    <= i_job.upper;
            r_pre      <= i_job.pre;
            r_pre_left <= prefix_len(i_job.pre);
            r_nd       <= 5'd0;
        end else if (r_state == ST_CONV) begin
            // Digits are found least significant first; shifting each new one in at
            // the front leaves the most significant digit at the head.
            r_dig[0] <= conv_digit;
            for (int i = 1; i < HEX_DIGITS; i++) begin
                r_dig[i] <= r_dig[i-1];
            end
            r_nd  <= r_nd + 5'd1;
            r_val <= conv_next;
        end else if (emit) begin
            if (r_pre_left != 3'd0) begin
                r_pre_left <= r_pre_left - 3'd1;
            end else begin
                r_nd <= r_nd - 5'd1;
                for (int i = 0; i < HEX_DIGITS - 1; i++) begin
                    r_dig[i] <= r_dig[i+1];
                end
            end
        end
        if (emit) begin
            r_m_char  <= emit_char;
            r_m_last  <= emit_last;
            r_m_count <= n_count;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_char  = r_m_char;
    assign o_m_last  = r_m_last;
    assign o_m_count = r_m_count;

endmodule
`default_nettype wire

// File: rtl/integer_to_ascii_formatter.sv
`default_nettype none
// Integer-to-ASCII formatter. Each input word carries a command in tuser and a 64-bit value
// in tdata; the block returns the text of the value one character per output word, most
// significant first, with tlast on the final character and the running character count
// (saturating, reset by the clear command) beside each character. Commands are queued
// in a short FIFO so the input side keeps accepting while text is being produced; clear
// emits nothing, and codes 6 and 7 are taken and dropped. Each queued command occupies
// the converter while it is loaded, then while its digits are found one per cycle (decimal
// digits come from a reciprocal multiply by ten, hex digits from a nibble shift), then while
// its characters go out one per cycle through the output register when the output side does
// not stall; the next command is taken only once its last character is in the output register.
module integer_to_ascii_formatter
    import ifmt_pkg::*;
#(
    parameter int FIFO_DEPTH = IFMT_FIFO_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // value
    input  wire logic [2:0]  s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // char_out [7:0], total_count [38:8], zero pad
    output logic             m_axis_tlast    // last_char
);

    logic             push;
    logic             room;
    t_job             front_job;
    t_job             q_job;
    logic             q_valid;
    logic             pop;
    logic [7:0]       out_char;
    logic [CNT_W-1:0] out_count;

    ifmt_front u_front (
        .i_valid (s_axis_tvalid),
        .i_cmd   (s_axis_tuser),
        .i_value (s_axis_tdata),
        .i_room  (room),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_job   (front_job)
    );

    ifmt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_room  (room),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ifmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (pop),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_char    (out_char),
        .o_m_last    (m_axis_tlast),
        .o_m_count   (out_count)
    );

    assign m_axis_tdata = {1'b0, out_count, out_char};

endmodule
`default_nettype wire

// File: rtl/ifmt_checker.sv
`default_nettype none
`include "integer_to_ascii_formatter_assert.svh"
module ifmt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    `IFMT_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")
    `IFMT_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")
    `IFMT_ASSERT_SAME(a_char_range, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[7:0] >= 8'h28) && (m_axis_tdata[7:0] <= 8'h7a), "character outside the formatter alphabet")
    `IFMT_ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[39] == 1'b0, "padding bit of the output word is set")
    `IFMT_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n, !m_axis_tvalid, "output word present right after reset")

endmodule

bind integer_to_ascii_formatter ifmt_checker u_ifmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: bench/tb.sv
module tb;
    import ifmt_pkg::*;

    // Codes 6 and 7 have no meaning; the block takes such words and drops them.
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_TAIL    = 40;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 64;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [7:0]       ch;
        logic             last;
        logic [CNT_W-1:0] count;
    } t_char_word;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] val;
        bit          drain_first;
    } t_print_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // value
    logic [2:0]  s_axis_tuser = '0;    // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // char_out [7:0], total_count [38:8], zero pad
    logic        m_axis_tlast;         // last_char

    t_print_req       print_reqs[$];
    t_char_word       expected_chars[$];
    logic [CNT_W-1:0] chars_since_clear = '0;

    logic       in_taken = 1'b0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         quiet_cycles = 0;
    int         mismatches = 0;
    int         printed_items = 0;
    int         pick;
    logic [2:0] rand_cmd;
    t_print_req next_req;
    t_char_word got_char;
    t_char_word want_char;

    integer_to_ascii_formatter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Builds the text of one command and queues one expected word per character.
    function automatic void predict_text(input logic [2:0] cmd, input logic [63:0] val);
        logic [7:0]  text [0:17];
        logic [7:0]  rev [0:15];
        logic [31:0] mag;
        logic [31:0] digit;
        logic [63:0] bits;
        logic [3:0]  nib;
        int          n;
        int          k;
        t_char_word  w;
        n = 0;
        k = 0;
        case (cmd)
            CMD_SDEC, CMD_UDEC: begin
                mag = val[31:0];
                if (cmd == CMD_SDEC && val[31]) begin
                    text[n] = "-";
                    n++;
                    mag = 32'd0 - val[31:0];
                end
                do begin
                    digit = mag % 32'd10;
                    rev[k] = 8'h30 + digit[7:0];
                    k++;
                    mag = mag / 32'd10;
                end while (mag != 0);
            end
            CMD_HEXL, CMD_HEXU, CMD_PTR: begin
                bits = (cmd == CMD_PTR) ? val : {32'd0, val[31:0]};
                if (cmd == CMD_PTR && val == 64'd0) begin
                    text[0] = "(";
                    text[1] = "n";
                    text[2] = "i";
                    text[3] = "l";
                    text[4] = ")";
                    n = 5;
                end else begin
                    if (cmd == CMD_PTR) begin
                        text[0] = "0";
                        text[1] = "x";
                        n = 2;
                    end
                    do begin
                        nib = bits[3:0];
                        if (nib < 4'd10) begin
                            rev[k] = 8'h30 + {4'd0, nib};
                        end else if (cmd == CMD_HEXU) begin
                            rev[k] = 8'h37 + {4'd0, nib};
                        end else begin
                            rev[k] = 8'h57 + {4'd0, nib};
                        end
                        k++;
                        bits = bits >> 4;
                    end while (bits != 0);
                end
            end
            CMD_CLR: begin
                chars_since_clear = '0;
            end
            default: begin
            end
        endcase
        while (k > 0) begin
            k--;
            text[n] = rev[k];
            n++;
        end
        for (int i = 0; i < n; i++) begin
            if (chars_since_clear != COUNT_MAX) begin
                chars_since_clear = chars_since_clear + 1'b1;
            end
            w.ch = text[i];
            w.last = (i == n - 1);
            w.count = chars_since_clear;
            expected_chars.push_back(w);
        end
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: v = v >> $urandom_range(0, 63);
            1: v = v >> $urandom_range(32, 63);
            2: v = {v[63:32], 32'h8000_0000};
            3: v = {v[63:32], 32'hFFFF_FFFF};
            4: v = {v[63:32], 32'd0};
            5: v = $urandom_range(0, 1) ? 64'd0 : 64'(v[3:0]);
            default: begin
            end
        endcase
        return v;
    endfunction

    task automatic add_print(input logic [2:0] cmd, input logic [63:0] val,
                             input bit drain_first = 1'b0);
        t_print_req r;
        r.cmd = cmd;
        r.val = val;
        r.drain_first = drain_first;
        print_reqs.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input t_char_word want,
                                 input t_char_word got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("mismatch (%s): expected char %h last %b count %0d,",
                     what, want.ch, want.last, want.count,
                     " got char %h last %b count %0d", got.ch, got.last, got.count);
        end
    endtask

    // Sender: a new word goes out once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (in_taken || !s_axis_tvalid)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (print_reqs.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 8);
                s_axis_tvalid <= 1'b0;
            end else if (print_reqs.size() != 0 &&
                         !(print_reqs[0].drain_first && expected_chars.size() != 0)) begin
                next_req = print_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_req.val;
                s_axis_tuser <= next_req.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (print_reqs.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Prediction runs before the check so both see one consistent queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_text(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_char.ch = m_axis_tdata[7:0];
                got_char.last = m_axis_tlast;
                got_char.count = m_axis_tdata[38:8];
                if (expected_chars.size() == 0) begin
                    note_mismatch("unexpected word", '0, got_char);
                end else begin
                    want_char = expected_chars.pop_front();
                    if (got_char.ch !== want_char.ch || got_char.last !== want_char.last ||
                        got_char.count !== want_char.count) begin
                        note_mismatch("character", want_char, got_char);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        // Directed: field extremes, every mode and the corner cases.
        add_print(CMD_SDEC, 64'd0);
        add_print(CMD_SDEC, 64'd1);
        add_print(CMD_SDEC, 64'h0000_0000_FFFF_FFFF);
        add_print(CMD_SDEC, 64'h0000_0000_8000_0000);
        add_print(CMD_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
        add_print(CMD_UDEC, 64'hFFFF_FFFF_0000_0000);
        add_print(CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
        add_print(CMD_UDEC, 64'h5555_5555_3B9A_CA00);
        add_print(CMD_HEXL, 64'd0);
        add_print(CMD_HEXL, 64'hAAAA_AAAA_DEAD_BEEF);
        add_print(CMD_HEXU, 64'h0000_0000_ABCD_EF01);
        add_print(CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
        add_print(CMD_PTR, 64'd0);
        add_print(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        add_print(CMD_PTR, 64'd1);
        add_print(CMD_PTR, 64'h0000_0001_0000_0000);
        add_print(CMD_PTR, 64'hFEDC_BA98_7654_3210);
        add_print(CMD_UNUSED_6, 64'hFFFF_FFFF_FFFF_FFFF);
        add_print(CMD_UNUSED_7, 64'd0);
        add_print(CMD_CLR, 64'hFFFF_FFFF_FFFF_FFFF);
        add_print(CMD_CLR, 64'd0);
        add_print(CMD_UDEC, 64'd7);
        add_print(CMD_HEXL, 64'h0000_0000_0000_00FF);

        // The first random word waits until the directed text has all come out.
        while (printed_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                rand_cmd = CMD_SDEC;
            end else if (pick < 40) begin
                rand_cmd = CMD_UDEC;
            end else if (pick < 58) begin
                rand_cmd = CMD_HEXL;
            end else if (pick < 76) begin
                rand_cmd = CMD_HEXU;
            end else if (pick < 94) begin
                rand_cmd = CMD_PTR;
            end else if (pick < 97) begin
                rand_cmd = CMD_CLR;
            end else if (pick < 99) begin
                rand_cmd = CMD_UNUSED_6;
            end else begin
                rand_cmd = CMD_UNUSED_7;
            end
            add_print(rand_cmd, rand_value(),
                      printed_items == 0 || printed_items == RANDOM_ITEMS / 2);
            if (rand_cmd != CMD_UNUSED_6 && rand_cmd != CMD_UNUSED_7) begin
                printed_items++;
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (print_reqs.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: integer_to_ascii_formatter.f
+incdir+rtl
rtl/ifmt_pkg.sv
rtl/ifmt_front.sv
rtl/ifmt_fifo.sv
rtl/ifmt_back.sv
rtl/integer_to_ascii_formatter.sv
rtl/ifmt_checker.sv
bench/tb.sv
